FILE: sv/rmsid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsid_pkg
// Shared widths, constants and register indexes of the RMS image difference.
// ----------------------------------------------------------------------------
package rmsid_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DIM_W     = 13;
    localparam int RES_W     = 17;
    localparam int SUM_W     = 60;
    localparam int CNT_W     = 25;
    localparam int SQ_W      = 33;
    localparam int ADD_W     = 35;
    localparam int DVSR_W    = CNT_W + 2;
    localparam int ROOT_W    = 17;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [RES_W-1:0] ONE_Q16   = RES_W'(65536);
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAXVAL_A = 3'd0,
        REG_MAXVAL_B = 3'd1,
        REG_WIDTH_A  = 3'd2,
        REG_HEIGHT_A = 3'd3,
        REG_WIDTH_B  = 3'd4,
        REG_HEIGHT_B = 3'd5
    } cfg_reg_t;

endpackage

FILE: sv/rmsid_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsid_lane
// One color channel: scales both samples into Q1.16 with a bit-serial
// division by the maximum value, then squares their difference.
// ----------------------------------------------------------------------------
module rmsid_lane import rmsid_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] sample_a,
    input  logic [SAMPLE_W-1:0] sample_b,
    input  logic [SAMPLE_W-1:0] maxval_a,
    input  logic [SAMPLE_W-1:0] maxval_b,
    output logic                done,
    output logic [SQ_W-1:0]     square
);

    localparam int STEP_W = $clog2(SAMPLE_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SAMPLE_W - 1);

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                fin_reg, fin_next;
    logic                done_reg, done_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;

    logic [SAMPLE_W-1:0] sample_s [2];
    logic [SAMPLE_W-1:0] maxval_s [2];
    logic [RES_W-1:0]    scaled   [2];
    logic [RES_W-1:0]    diff;
    logic [2*RES_W-1:0]  product;

    assign sample_s[0] = sample_a;
    assign sample_s[1] = sample_b;
    assign maxval_s[0] = maxval_a;
    assign maxval_s[1] = maxval_b;

    for (genvar k = 0; k < 2; k++) begin : g_side
        logic [SAMPLE_W-1:0] rem_reg, rem_next;
        logic [SAMPLE_W-1:0] num_reg, num_next;
        logic [SAMPLE_W-1:0] dvsr_reg, dvsr_next;
        logic                sat_reg, sat_next;
        logic [SAMPLE_W-1:0] dv;
        logic [SAMPLE_W:0]   trial;
        logic                ge;

        always_comb begin
            dv    = (maxval_s[k] == '0) ? SAMPLE_W'(1) : maxval_s[k];
            trial = {rem_reg, num_reg[SAMPLE_W-1]};
            ge    = trial >= {1'b0, dvsr_reg};
            rem_next  = rem_reg;
            num_next  = num_reg;
            dvsr_next = dvsr_reg;
            sat_next  = sat_reg;
            if (start) begin
                // numerator is sample * 2^16 + maxval / 2, remainder starts at sample
                rem_next  = sample_s[k];
                num_next  = {1'b0, dv[SAMPLE_W-1:1]};
                dvsr_next = dv;
                sat_next  = sample_s[k] >= dv;
            end else if (busy_reg) begin
                rem_next = ge ? SAMPLE_W'(trial - {1'b0, dvsr_reg}) : trial[SAMPLE_W-1:0];
                num_next = {num_reg[SAMPLE_W-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            dvsr_reg <= dvsr_next;
            sat_reg  <= sat_next;
        end

        assign scaled[k] = sat_reg ? ONE_Q16 : {1'b0, num_reg};
    end

    always_comb begin
        diff    = (scaled[0] > scaled[1]) ? scaled[0] - scaled[1] : scaled[1] - scaled[0];
        product = diff * diff;
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
            end
        end
        fin_next  = busy_reg && (step_reg == STEP_LAST) && !start;
        done_next = fin_reg;
        sq_next   = fin_reg ? product[SQ_W-1:0] : sq_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        sq_reg <= sq_next;
    end

    assign done   = done_reg;
    assign square = sq_reg;

endmodule

FILE: sv/rmsid_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsid_div
// Restoring divider, one quotient bit per cycle: sum over three times count.
// ----------------------------------------------------------------------------
module rmsid_div import rmsid_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              done,
    output logic [SUM_W-1:0]  quotient
);

    localparam int CNT_BITS = $clog2(SUM_W);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SUM_W - 1);

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DVSR_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [DVSR_W-1:0]   dvsr_reg, dvsr_next;
    logic [DVSR_W:0]     trial;
    logic                ge;

    always_comb begin
        trial     = {rem_reg, dvd_reg[SUM_W-1]};
        ge        = trial >= {1'b0, dvsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvsr_next = dvsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvsr_next = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? DVSR_W'(trial - {1'b0, dvsr_reg}) : trial[DVSR_W-1:0];
            dvd_next = {dvd_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: sv/rmsid_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsid_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmsid_sqrt import rmsid_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W    = ROOT_W + 2;
    localparam int CNT_BITS = $clog2(ROOT_W);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ROOT_W - 1);

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W+1:0]    shifted;
    logic [REM_W+1:0]    trial;
    logic                ge;

    always_comb begin
        shifted   = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = (REM_W+2)'({root_reg, 2'b01});
        ge        = shifted >= trial;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            rad_next  = radicand;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? REM_W'(shifted - trial) : REM_W'(shifted);
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: sv/rms_image_difference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_image_difference
// RMS error between two RGB images streamed as pixel pairs.
// ----------------------------------------------------------------------------
// Each accepted request is one pixel pair; three channel lanes scale the
// samples by their image maximum and square the differences, and a merge stage
// adds them into a saturating 60-bit sum with a pair count. The next pair is
// taken only once the current one is accumulated and the block is idle again,
// a wait set by the 16-step serial division in the lanes. After the pair marked
// last a divider forms the mean, a square root follows and the result is offered
// on the m_ side; the sum and count start over. When the configured image sizes
// differ by more than one pixel in either direction the result carries
// too_different and an error of 1.0 right after accumulation.
module rms_image_difference import rmsid_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_red_a,
    input  logic [SAMPLE_W-1:0]  s_green_a,
    input  logic [SAMPLE_W-1:0]  s_blue_a,
    input  logic [SAMPLE_W-1:0]  s_red_b,
    input  logic [SAMPLE_W-1:0]  s_green_b,
    input  logic [SAMPLE_W-1:0]  s_blue_b,
    input  logic                 s_last_pixel,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [RES_W-1:0]     m_rms_error,
    output logic                 m_too_different
);

    localparam int DIM_REQ_W = $clog2(MAX_DIM + 1);
    localparam int CLAMP_W   = (DIM_REQ_W > DIM_W) ? DIM_REQ_W : DIM_W;
    localparam logic [CLAMP_W-1:0] MAX_DIM_C = CLAMP_W'(MAX_DIM);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCALE  = 7'b0000010,
        ST_ACCUM  = 7'b0000100,
        ST_LAUNCH = 7'b0001000,
        ST_DIVIDE = 7'b0010000,
        ST_ROOT   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [SAMPLE_W-1:0] maxval_a_reg, maxval_a_next;
    logic [SAMPLE_W-1:0] maxval_b_reg, maxval_b_next;
    logic [DIM_W-1:0]    width_a_reg, width_a_next;
    logic [DIM_W-1:0]    height_a_reg, height_a_next;
    logic [DIM_W-1:0]    width_b_reg, width_b_next;
    logic [DIM_W-1:0]    height_b_reg, height_b_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                last_reg, last_next;
    logic [RES_W-1:0]    res_reg, res_next;
    logic                flag_reg, flag_next;
    logic                m_valid_reg, m_valid_next;
    logic [RES_W-1:0]    m_rms_reg, m_rms_next;
    logic                m_flag_reg, m_flag_next;

    logic                accept;
    logic [SAMPLE_W-1:0] lane_a [3];
    logic [SAMPLE_W-1:0] lane_b [3];
    logic [2:0]          lane_done;
    logic [SQ_W-1:0]     lane_sq [3];
    logic [ADD_W-1:0]    add;
    logic [SUM_W:0]      sum_wide;
    logic                far;
    logic                div_start;
    logic                div_done;
    logic [DVSR_W-1:0]   divisor;
    logic [SUM_W-1:0]    quotient;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [RAD_W-1:0]    radicand;
    logic [ROOT_W-1:0]   root;

    function automatic logic dims_far(input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y);
        logic [CLAMP_W-1:0] xc;
        logic [CLAMP_W-1:0] yc;
        logic [CLAMP_W-1:0] d;
        xc = CLAMP_W'(x);
        yc = CLAMP_W'(y);
        xc = (xc > MAX_DIM_C) ? MAX_DIM_C : xc;
        yc = (yc > MAX_DIM_C) ? MAX_DIM_C : yc;
        d  = (xc > yc) ? xc - yc : yc - xc;
        return d > CLAMP_W'(1);
    endfunction

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    assign lane_a[0] = s_red_a;
    assign lane_a[1] = s_green_a;
    assign lane_a[2] = s_blue_a;
    assign lane_b[0] = s_red_b;
    assign lane_b[1] = s_green_b;
    assign lane_b[2] = s_blue_b;

    for (genvar c = 0; c < 3; c++) begin : g_lane
        rmsid_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (accept),
            .sample_a (lane_a[c]),
            .sample_b (lane_b[c]),
            .maxval_a (maxval_a_reg),
            .maxval_b (maxval_b_reg),
            .done     (lane_done[c]),
            .square   (lane_sq[c])
        );
    end

    assign divisor = DVSR_W'(count_reg) + (DVSR_W'(count_reg) << 1);

    rmsid_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // quotients beyond the radicand range only give a capped root
    assign radicand = (quotient[SUM_W-1:RAD_W] != '0) ? '1 : quotient[RAD_W-1:0];

    rmsid_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb begin
        maxval_a_next = maxval_a_reg;
        maxval_b_next = maxval_b_reg;
        width_a_next  = width_a_reg;
        height_a_next = height_a_reg;
        width_b_next  = width_b_reg;
        height_b_next = height_b_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAXVAL_A: maxval_a_next = cfg_data;
                REG_MAXVAL_B: maxval_b_next = cfg_data;
                REG_WIDTH_A:  width_a_next  = cfg_data[DIM_W-1:0];
                REG_HEIGHT_A: height_a_next = cfg_data[DIM_W-1:0];
                REG_WIDTH_B:  width_b_next  = cfg_data[DIM_W-1:0];
                REG_HEIGHT_B: height_b_next = cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        far = dims_far(width_a_reg, width_b_reg) || dims_far(height_a_reg, height_b_reg);
        add = ADD_W'(lane_sq[0]) + ADD_W'(lane_sq[1]) + ADD_W'(lane_sq[2]);
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(add);

        state_next   = state_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        res_next     = res_reg;
        flag_next    = flag_reg;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_rms_next   = m_rms_reg;
        m_flag_next  = m_flag_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    last_next  = s_last_pixel;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (&lane_done) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = last_reg ? ST_LAUNCH : ST_IDLE;
            end
            ST_LAUNCH: begin
                if (far) begin
                    res_next   = ONE_Q16;
                    flag_next  = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
                sum_next   = '0;
                count_next = '0;
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    res_next   = (RES_W'(root) > ONE_Q16) ? ONE_Q16 : RES_W'(root);
                    flag_next  = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rms_next   = res_reg;
                    m_flag_next  = flag_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            maxval_a_reg <= SAMPLE_W'(255);
            maxval_b_reg <= SAMPLE_W'(255);
            width_a_reg  <= DIM_W'(1);
            height_a_reg <= DIM_W'(1);
            width_b_reg  <= DIM_W'(1);
            height_b_reg <= DIM_W'(1);
            sum_reg      <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            maxval_a_reg <= maxval_a_next;
            maxval_b_reg <= maxval_b_next;
            width_a_reg  <= width_a_next;
            height_a_reg <= height_a_next;
            width_b_reg  <= width_b_next;
            height_b_reg <= height_b_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg   <= last_next;
        res_reg    <= res_next;
        flag_reg   <= flag_next;
        m_rms_reg  <= m_rms_next;
        m_flag_reg <= m_flag_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_rms_error     = m_rms_reg;
    assign m_too_different = m_flag_reg;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RMS image difference block: a directed table of
// pixel pairs and register settings, then random frames under several register
// settings, each result checked against a bit-exact model in the bench or a table value.
// ----------------------------------------------------------------------------
module testbench;
    import rmsid_pkg::*;

    localparam int DIM_LIMIT   = 4096;
    localparam int IDLE_WAIT   = 150;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 120;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_a;
        logic [SAMPLE_W-1:0] green_a;
        logic [SAMPLE_W-1:0] blue_a;
        logic [SAMPLE_W-1:0] red_b;
        logic [SAMPLE_W-1:0] green_b;
        logic [SAMPLE_W-1:0] blue_b;
        logic                last;
    } pixel_pair_t;

    typedef struct packed {
        logic [RES_W-1:0] rms;
        logic             flag;
    } rms_result_t;

    typedef logic [0:5][SAMPLE_W-1:0] cfg_words_t;

    typedef struct {
        int          cfg_sel;
        pixel_pair_t px;
        bit          typed;
        rms_result_t want;
    } dir_row_t;

    typedef enum int {
        CFG_FULL_SCALE,
        CFG_UNIT_MAX_NEAR,
        CFG_RANDOM_MAX,
        CFG_FAR_APART,
        CFG_SMALLEST,
        CFG_RAW_WORDS
    } cfg_style_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_red_a;
    logic [SAMPLE_W-1:0]  s_green_a;
    logic [SAMPLE_W-1:0]  s_blue_a;
    logic [SAMPLE_W-1:0]  s_red_b;
    logic [SAMPLE_W-1:0]  s_green_b;
    logic [SAMPLE_W-1:0]  s_blue_b;
    logic                 s_last_pixel;
    logic                 m_valid;
    logic                 m_ready;
    logic [RES_W-1:0]     m_rms_error;
    logic                 m_too_different;

    rms_image_difference #(
        .MAX_DIM(DIM_LIMIT)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red_a        (s_red_a),
        .s_green_a      (s_green_a),
        .s_blue_a       (s_blue_a),
        .s_red_b        (s_red_b),
        .s_green_b      (s_green_b),
        .s_blue_b       (s_blue_b),
        .s_last_pixel   (s_last_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rms_error    (m_rms_error),
        .m_too_different(m_too_different)
    );

    // model copy of the registers and the running frame
    logic [SAMPLE_W-1:0] maxv_a, maxv_b;
    logic [DIM_W-1:0]    wid_a, hgt_a, wid_b, hgt_b;
    logic [SUM_W-1:0]    frame_sum;
    logic [CNT_W-1:0]    frame_pairs;

    rms_result_t rms_expected_q [$];
    rms_result_t oldest_rms;
    int unsigned mismatches;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int          hold_left;

    cfg_words_t dir_cfg_sets [7] = '{
        '{255, 255, 1, 1, 1, 1},
        '{65535, 65535, 100, 20, 102, 20},
        '{65535, 65535, 30, 7, 30, 9},
        '{65535, 65535, 10, 5, 11, 4},
        '{0, 1, 1, 1, 1, 1},
        '{255, 1000, 65535, 4096, 4095, 8000},
        '{1, 65535, 8191, 1, 4094, 2}
    };

    dir_row_t directed_rows [19] = '{
        '{0, '{0, 0, 0, 0, 0, 0, 1}, 1, '{0, 0}},
        '{0, '{255, 255, 255, 0, 0, 0, 1}, 1, '{ONE_Q16, 0}},
        '{0, '{65535, 65535, 65535, 255, 255, 255, 1}, 1, '{0, 0}},
        '{0, '{10, 200, 37, 12, 190, 40, 0}, 0, '{0, 0}},
        '{0, '{128, 64, 32, 127, 66, 30, 0}, 0, '{0, 0}},
        '{0, '{0, 255, 100, 255, 0, 101, 1}, 0, '{0, 0}},
        '{1, '{1000, 2000, 3000, 1000, 2000, 3000, 0}, 0, '{0, 0}},
        '{0, '{0, 0, 0, 0, 0, 0, 1}, 1, '{ONE_Q16, 1}},
        '{2, '{5, 5, 5, 5, 5, 5, 1}, 1, '{ONE_Q16, 1}},
        '{3, '{65535, 0, 0, 0, 0, 0, 1}, 0, '{0, 0}},
        '{0, '{65535, 65535, 65535, 65534, 65535, 0, 0}, 0, '{0, 0}},
        '{0, '{32768, 1, 65535, 32767, 0, 65535, 1}, 0, '{0, 0}},
        '{4, '{1, 1, 1, 0, 0, 0, 1}, 1, '{ONE_Q16, 0}},
        '{0, '{0, 1, 0, 1, 0, 1, 1}, 0, '{0, 0}},
        '{5, '{100, 200, 255, 400, 800, 1000, 1}, 0, '{0, 0}},
        '{0, '{0, 0, 0, 0, 0, 0, 1}, 1, '{0, 0}},
        '{6, '{65535, 0, 65535, 0, 65535, 0, 1}, 1, '{ONE_Q16, 1}},
        '{0, '{0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0}},
        '{0, '{1, 2, 3, 4, 5, 6, 1}, 1, '{ONE_Q16, 1}}
    };

    function automatic longint unsigned to_q16(logic [SAMPLE_W-1:0] s,
                                               logic [SAMPLE_W-1:0] mx);
        longint unsigned d, q;
        d = (mx == 0) ? 1 : longint'(mx);
        q = (longint'(s) * 65536 + d / 2) / d;
        return (q > ONE_Q16) ? longint'(ONE_Q16) : q;
    endfunction

    function automatic longint unsigned sq_gap(longint unsigned a, longint unsigned b);
        longint unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    function automatic bit dims_apart(logic [DIM_W-1:0] x, logic [DIM_W-1:0] y);
        int xc, yc;
        xc = (x > DIM_LIMIT) ? DIM_LIMIT : int'(x);
        yc = (y > DIM_LIMIT) ? DIM_LIMIT : int'(y);
        return ((xc > yc) ? xc - yc : yc - xc) > 1;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root, t;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            t = root | (64'd1 << b);
            if (t * t <= v) root = t;
        end
        return root;
    endfunction

    task automatic predict_pair(input pixel_pair_t p, output bit emits,
                                output rms_result_t r);
        longint unsigned add, mean, root;
        add = sq_gap(to_q16(p.red_a, maxv_a), to_q16(p.red_b, maxv_b))
            + sq_gap(to_q16(p.green_a, maxv_a), to_q16(p.green_b, maxv_b))
            + sq_gap(to_q16(p.blue_a, maxv_a), to_q16(p.blue_b, maxv_b));
        if (add > SUM_MAX - frame_sum) frame_sum = SUM_MAX;
        else frame_sum = SUM_W'(frame_sum + add);
        if (frame_pairs != COUNT_MAX) frame_pairs = frame_pairs + CNT_W'(1);
        emits = p.last;
        r = '0;
        if (p.last) begin
            if (dims_apart(wid_a, wid_b) || dims_apart(hgt_a, hgt_b)) begin
                r.rms  = ONE_Q16;
                r.flag = 1'b1;
            end else begin
                mean = longint'(frame_sum) / (3 * longint'(frame_pairs));
                root = floor_sqrt(mean);
                r.rms  = (root > ONE_Q16) ? ONE_Q16 : root[RES_W-1:0];
                r.flag = 1'b0;
            end
            frame_sum   = '0;
            frame_pairs = '0;
        end
    endtask

    function automatic cfg_words_t random_config(cfg_style_t style);
        cfg_words_t  w;
        int unsigned bw, bh;
        bw = $urandom_range(1, 4096);
        bh = $urandom_range(1, 4096);
        w[REG_MAXVAL_A] = SAMPLE_W'($urandom_range(1, 65535));
        w[REG_MAXVAL_B] = SAMPLE_W'($urandom_range(1, 65535));
        w[REG_WIDTH_A]  = SAMPLE_W'(bw);
        w[REG_HEIGHT_A] = SAMPLE_W'(bh);
        w[REG_WIDTH_B]  = SAMPLE_W'(bw);
        w[REG_HEIGHT_B] = SAMPLE_W'(bh);
        case (style)
            CFG_FULL_SCALE: begin
                w = '{65535, 65535, 4096, 4096, 4096, 4096};
            end
            CFG_UNIT_MAX_NEAR: begin
                w[REG_MAXVAL_A] = 1;
                w[REG_MAXVAL_B] = 1;
                w[REG_WIDTH_B]  = SAMPLE_W'((bw == 4096) ? bw - 1 : bw + 1);
                w[REG_HEIGHT_B] = SAMPLE_W'((bh == 1) ? bh + 1 : bh - 1);
            end
            CFG_FAR_APART: begin
                w[REG_WIDTH_B] = SAMPLE_W'((bw > 2048) ? bw - $urandom_range(2, 2000)
                                                       : bw + $urandom_range(2, 2000));
            end
            CFG_SMALLEST: begin
                w = '{255, 65535, 1, 1, 1, 1};
            end
            CFG_RAW_WORDS: begin
                w = {$urandom, $urandom, $urandom};
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    function automatic pixel_pair_t random_pixel(bit last);
        pixel_pair_t p;
        int          ma, mb, pick, bv;
        int          a [3];
        int          b [3];
        ma   = (maxv_a == 0) ? 1 : int'(maxv_a);
        mb   = (maxv_b == 0) ? 1 : int'(maxv_b);
        pick = $urandom_range(9);
        for (int c = 0; c < 3; c++) begin
            if (pick < 2) begin
                a[c] = $urandom_range(65535);
                b[c] = $urandom_range(65535);
            end else if (pick < 6) begin
                // second image close to the first, rescaled to its maximum
                a[c] = $urandom_range(ma);
                bv   = int'((longint'(a[c]) * mb) / ma) + int'($urandom_range(6)) - 3;
                b[c] = (bv < 0) ? 0 : ((bv > mb) ? mb : bv);
            end else begin
                a[c] = $urandom_range(ma);
                b[c] = $urandom_range(mb);
            end
        end
        p.red_a   = SAMPLE_W'(a[0]);
        p.green_a = SAMPLE_W'(a[1]);
        p.blue_a  = SAMPLE_W'(a[2]);
        p.red_b   = SAMPLE_W'(b[0]);
        p.green_b = SAMPLE_W'(b[1]);
        p.blue_b  = SAMPLE_W'(b[2]);
        p.last    = last;
        return p;
    endfunction

    task automatic load_config(input cfg_words_t w);
        cfg_reg_t r;
        r = REG_MAXVAL_A;
        do begin
            cfg_wr_en <= 1'b1;
            cfg_index <= r;
            cfg_data  <= w[r];
            case (r)
                REG_MAXVAL_A: maxv_a = w[r];
                REG_MAXVAL_B: maxv_b = w[r];
                REG_WIDTH_A:  wid_a  = w[r][DIM_W-1:0];
                REG_HEIGHT_A: hgt_a  = w[r][DIM_W-1:0];
                REG_WIDTH_B:  wid_b  = w[r][DIM_W-1:0];
                REG_HEIGHT_B: hgt_b  = w[r][DIM_W-1:0];
                default: begin
                end
            endcase
            @(posedge aclk);
            r = r.next();
        end while (r != REG_MAXVAL_A);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pixel(input pixel_pair_t p, input bit typed,
                              input rms_result_t want);
        bit          emits;
        rms_result_t pred;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_red_a      <= p.red_a;
        s_green_a    <= p.green_a;
        s_blue_a     <= p.blue_a;
        s_red_b      <= p.red_b;
        s_green_b    <= p.green_b;
        s_blue_b     <= p.blue_b;
        s_last_pixel <= p.last;
        do @(posedge aclk); while (!s_ready);
        predict_pair(p, emits, pred);
        if (emits) rms_expected_q.push_back(typed ? want : pred);
    endtask

    // drain all results, then give an in-flight request time to finish
    task automatic settle();
        s_valid <= 1'b0;
        while (rms_expected_q.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rms_expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d / %0d",
                         $time, m_rms_error, m_too_different);
            end else begin
                oldest_rms = rms_expected_q.pop_front();
                if (m_rms_error !== oldest_rms.rms) begin
                    mismatches++;
                    $display("%0t: rms_error expected %0d, actual %0d",
                             $time, oldest_rms.rms, m_rms_error);
                end
                if (m_too_different !== oldest_rms.flag) begin
                    mismatches++;
                    $display("%0t: too_different expected %0d, actual %0d",
                             $time, oldest_rms.flag, m_too_different);
                end
            end
        end
    end

    initial begin
        int left, len;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_MAXVAL_A;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_red_a      <= '0;
        s_green_a    <= '0;
        s_blue_a     <= '0;
        s_red_b      <= '0;
        s_green_b    <= '0;
        s_blue_b     <= '0;
        s_last_pixel <= 1'b0;
        maxv_a       = 255;
        maxv_b       = 255;
        wid_a        = 1;
        hgt_a        = 1;
        wid_b        = 1;
        hgt_b        = 1;
        frame_sum    = '0;
        frame_pairs  = '0;
        mismatches   = 0;
        hold_req     = 1'b0;
        hold_left    = 0;
        tx_idle_pct  = 30;
        rx_idle_pct  = 52;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg_sel != 0) begin
                settle();
                load_config(dir_cfg_sets[directed_rows[i].cfg_sel]);
            end
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES / 3) begin
                tx_idle_pct = 52;
                rx_idle_pct = 30;
            end
            if (phase == 2 * PHASES / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            settle();
            load_config(random_config(cfg_style_t'(phase % 6)));
            // long hold-off so that requests back up into the block
            if (phase == PHASES / 3) hold_req = 1'b1;
            left = PHASE_ITEMS;
            while (left > 0) begin
                if (phase == PHASES / 3 && left > PHASE_ITEMS - 30) len = 1;
                else if ($urandom_range(7) != 0) len = $urandom_range(1, 12);
                else len = $urandom_range(13, 60);
                if (len > left) len = left;
                for (int k = 1; k <= len; k++) send_pixel(random_pixel(k == len), 1'b0, '0);
                left = left - len;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
